// ===== rtl/bitmap_slab_slot_allocator_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef BITMAP_SLAB_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLAB_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled in reset
`define BSSA_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("allocator assertion failed");

// Next-cycle implication, sampled on clk, disabled in reset
`define BSSA_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("allocator assertion failed");

`endif

// ===== rtl/bssa_pkg.sv =====
package bssa_pkg;

    localparam int SLOT_BYTES   = 64;
    localparam int BUF_COUNT    = 64;
    localparam int NUM_BLOCKS   = 16;
    localparam int MAP_BYTES    = 64;
    localparam int BLK_W        = 4;
    localparam int BYTE_W       = 6;
    localparam int BIT_W        = 3;
    localparam int OPEN_W       = 5;
    localparam int BUF_W        = 6;
    localparam int HANDLE_W     = 13;
    localparam int REQ_W        = 16;
    localparam int MAP_ADDR_W   = BLK_W + BYTE_W;

    typedef enum logic [2:0] {
        ST_SLAB      = 3'd0,
        ST_BUFFER    = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_EXHAUSTED = 3'd3,
        ST_FREED     = 3'd4,
        ST_BAD_FREE  = 3'd5
    } status_t;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic {
        POOL_SLAB   = 1'b0,
        POOL_BUFFER = 1'b1
    } pool_t;

    // Index of the highest set bit of a 64-bit vector
    function automatic logic [BYTE_W-1:0] highest_set(input logic [MAP_BYTES-1:0] v);
        logic [BYTE_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAP_BYTES; i++)
        begin
            if (v[i])
            begin
                idx = BYTE_W'(i);
            end
        end
        return idx;
    endfunction

    // Index of the lowest set bit of a byte
    function automatic logic [BIT_W-1:0] lowest_set(input logic [7:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    // Index of the lowest clear bit of the buffer flags
    function automatic logic [BUF_W-1:0] lowest_clear(input logic [BUF_COUNT-1:0] v);
        logic [BUF_W-1:0] idx;
        idx = '0;
        for (int i = BUF_COUNT - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                idx = BUF_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/bssa_if.sv =====
interface bssa_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [bssa_pkg::REQ_W-1:0]    request_bytes;
    logic                          free_pool;
    logic [bssa_pkg::HANDLE_W-1:0] free_handle;

    modport source (output valid, action, request_bytes, free_pool, free_handle,
                    input ready);
    modport sink (input valid, action, request_bytes, free_pool, free_handle,
                  output ready);
endinterface

interface bssa_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    status;
    logic [bssa_pkg::HANDLE_W-1:0] handle;

    modport source (output valid, status, handle, input ready);
    modport sink (input valid, status, handle, output ready);
endinterface

// ===== rtl/bitmap_slab_slot_allocator.sv =====
// Buffer grants, too-large requests and bad frees of a buffer or unopened block end
// at dispatch; slab frees pass through the free state; slab grants walk the ring of
// open blocks and then update the map, or open a block when no open block has a slot.
// One request in flight; the next is taken once the result sits in the output
// register. Block opening fills all 64 rows of the block's map memory.
// Reset (rst_n low, async) clears control state; map memories need no clearing
// pass since a block's rows are filled when it opens.
`include "bitmap_slab_slot_allocator_macros.svh"

module bitmap_slab_slot_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [bssa_pkg::REQ_W-1:0] cfg_wr_data,
    bssa_in_if.sink                    in_ch,
    bssa_out_if.source                 out_ch
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_SUM      = 7'b0000100,
        S_MAP      = 7'b0001000,
        S_OPEN     = 7'b0010000,
        S_FREE     = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t                                 state_reg, state_next;
    logic [bssa_pkg::REQ_W-1:0]             buf_req_reg;
    logic                                   action_reg;
    logic [bssa_pkg::REQ_W-1:0]             req_reg;
    logic                                   pool_reg;
    logic [bssa_pkg::HANDLE_W-1:0]          fh_reg;
    logic [bssa_pkg::BUF_COUNT-1:0]         buf_taken_reg, buf_taken_next;
    logic [bssa_pkg::BLK_W-1:0]             current_reg, current_next;
    logic [bssa_pkg::OPEN_W-1:0]            opened_reg, opened_next;
    logic [bssa_pkg::BLK_W-1:0]             blk_reg, blk_next;
    logic [bssa_pkg::BYTE_W-1:0]            byte_reg, byte_next;
    logic [bssa_pkg::OPEN_W-1:0]            walk_reg, walk_next;
    logic [bssa_pkg::BYTE_W-1:0]            fill_reg, fill_next;
    logic [2:0]                             res_status_reg, res_status_next;
    logic [bssa_pkg::HANDLE_W-1:0]          res_handle_reg, res_handle_next;
    logic                                   out_valid_reg;
    logic [2:0]                             out_status_reg;
    logic [bssa_pkg::HANDLE_W-1:0]          out_handle_reg;
    logic [bssa_pkg::BLK_W-1:0]             ring_reg [bssa_pkg::NUM_BLOCKS];

    // Slot free maps and per-block nonempty-byte summaries
    logic [7:0]                             map_mem [bssa_pkg::NUM_BLOCKS*bssa_pkg::MAP_BYTES];
    logic [bssa_pkg::MAP_BYTES-1:0]         sum_mem [bssa_pkg::NUM_BLOCKS];
    logic [7:0]                             map_q;
    logic [bssa_pkg::MAP_BYTES-1:0]         sum_q;
    logic                                   map_we;
    logic [bssa_pkg::MAP_ADDR_W-1:0]        map_waddr;
    logic [7:0]                             map_wdata;
    logic                                   sum_we;
    logic [bssa_pkg::BLK_W-1:0]             sum_waddr;
    logic [bssa_pkg::MAP_BYTES-1:0]         sum_wdata;
    logic                                   ring_open;

    logic [bssa_pkg::BLK_W-1:0]             nb;
    logic [bssa_pkg::BIT_W-1:0]             low_bit;
    logic [7:0]                             taken_byte;
    logic [bssa_pkg::BIT_W-1:0]             free_bit;
    logic [bssa_pkg::BLK_W-1:0]             fh_blk;
    logic                                   buf_hit;

    assign nb         = opened_reg[bssa_pkg::BLK_W-1:0];
    assign low_bit    = bssa_pkg::lowest_set(map_q);
    assign taken_byte = map_q & ~(8'd1 << low_bit);
    assign free_bit   = fh_reg[bssa_pkg::BIT_W-1:0];
    assign fh_blk     = fh_reg[bssa_pkg::HANDLE_W-1 -: bssa_pkg::BLK_W];
    assign buf_hit    = (buf_req_reg != '0) && (req_reg == buf_req_reg)
                        && !(&buf_taken_reg);

    assign in_ch.ready   = (state_reg == S_IDLE);
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.status = out_status_reg;
    assign out_ch.handle = out_handle_reg;

    // Sequencer: dispatch, ring walk, map update, block open, free
    always_comb
    begin
        state_next      = state_reg;
        buf_taken_next  = buf_taken_reg;
        current_next    = current_reg;
        opened_next     = opened_reg;
        blk_next        = blk_reg;
        byte_next       = byte_reg;
        walk_next       = walk_reg;
        fill_next       = fill_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        map_we          = 1'b0;
        map_waddr       = {blk_reg, byte_reg};
        map_wdata       = taken_byte;
        sum_we          = 1'b0;
        sum_waddr       = blk_reg;
        sum_wdata       = sum_q;
        ring_open       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                if (action_reg == bssa_pkg::ACT_ALLOC)
                begin
                    if (buf_hit)
                    begin
                        buf_taken_next[bssa_pkg::lowest_clear(buf_taken_reg)] = 1'b1;
                        res_status_next = bssa_pkg::ST_BUFFER;
                        res_handle_next = bssa_pkg::HANDLE_W'(
                            bssa_pkg::lowest_clear(buf_taken_reg));
                    end
                    else if (req_reg > bssa_pkg::REQ_W'(bssa_pkg::SLOT_BYTES))
                    begin
                        res_status_next = bssa_pkg::ST_TOO_LARGE;
                        res_handle_next = '0;
                    end
                    else if (opened_reg == '0)
                    begin
                        fill_next  = '0;
                        blk_next   = current_reg;
                        state_next = S_OPEN;
                    end
                    else
                    begin
                        blk_next   = current_reg;
                        walk_next  = '0;
                        state_next = S_SUM;
                    end
                end
                else
                begin
                    res_handle_next = fh_reg;
                    res_status_next = bssa_pkg::ST_BAD_FREE;
                    if (pool_reg == bssa_pkg::POOL_BUFFER)
                    begin
                        if ((fh_reg[bssa_pkg::HANDLE_W-1:bssa_pkg::BUF_W] == '0)
                            && buf_taken_reg[fh_reg[bssa_pkg::BUF_W-1:0]])
                        begin
                            buf_taken_next[fh_reg[bssa_pkg::BUF_W-1:0]] = 1'b0;
                            res_status_next = bssa_pkg::ST_FREED;
                        end
                    end
                    else if ({1'b0, fh_blk} < opened_reg)
                    begin
                        blk_next   = fh_blk;
                        byte_next  = fh_reg[bssa_pkg::BIT_W +: bssa_pkg::BYTE_W];
                        state_next = S_FREE;
                    end
                end
            end
            S_SUM:
            begin
                if (sum_q != '0)
                begin
                    byte_next  = bssa_pkg::highest_set(sum_q);
                    state_next = S_MAP;
                end
                else if (walk_reg + 5'd1 == opened_reg)
                begin
                    if (opened_reg == bssa_pkg::OPEN_W'(bssa_pkg::NUM_BLOCKS))
                    begin
                        res_status_next = bssa_pkg::ST_EXHAUSTED;
                        res_handle_next = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        fill_next  = '0;
                        blk_next   = current_reg;
                        state_next = S_OPEN;
                    end
                end
                else
                begin
                    walk_next = walk_reg + 5'd1;
                    blk_next  = ring_reg[blk_reg];
                end
            end
            S_MAP:
            begin
                map_we    = 1'b1;
                map_wdata = taken_byte;
                if (taken_byte == '0)
                begin
                    sum_we    = 1'b1;
                    sum_wdata = sum_q & ~(64'd1 << byte_reg);
                end
                current_next    = blk_reg;
                res_status_next = bssa_pkg::ST_SLAB;
                res_handle_next = {blk_reg, byte_reg, low_bit};
                state_next      = S_DONE;
            end
            S_OPEN:
            begin
                // Fill the new block's map, taking slot 504 on the last row
                map_we    = 1'b1;
                map_waddr = {nb, fill_reg};
                map_wdata = (&fill_reg) ? 8'hFE : 8'hFF;
                fill_next = fill_reg + 6'd1;
                if (&fill_reg)
                begin
                    sum_we          = 1'b1;
                    sum_waddr       = nb;
                    sum_wdata       = '1;
                    ring_open       = 1'b1;
                    opened_next     = opened_reg + 5'd1;
                    current_next    = nb;
                    res_status_next = bssa_pkg::ST_SLAB;
                    res_handle_next = {nb, {bssa_pkg::BYTE_W{1'b1}}, 3'd0};
                    state_next      = S_DONE;
                end
            end
            S_FREE:
            begin
                if (!map_q[free_bit])
                begin
                    map_we          = 1'b1;
                    map_wdata       = map_q | (8'd1 << free_bit);
                    sum_we          = 1'b1;
                    sum_wdata       = sum_q | (64'd1 << byte_reg);
                    res_status_next = bssa_pkg::ST_FREED;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            buf_req_reg   <= '0;
            buf_taken_reg <= '0;
            current_reg   <= '0;
            opened_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            buf_taken_reg <= buf_taken_next;
            current_reg   <= current_next;
            opened_reg    <= opened_next;
            if (cfg_wr_en)
            begin
                buf_req_reg <= cfg_wr_data;
            end
            if (state_reg == S_DONE && (!out_valid_reg || out_ch.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        blk_reg        <= blk_next;
        byte_reg       <= byte_next;
        walk_reg       <= walk_next;
        fill_reg       <= fill_next;
        res_status_reg <= res_status_next;
        res_handle_reg <= res_handle_next;
        if (in_ch.valid && in_ch.ready)
        begin
            action_reg <= in_ch.action;
            req_reg    <= in_ch.request_bytes;
            pool_reg   <= in_ch.free_pool;
            fh_reg     <= in_ch.free_handle;
        end
        if (state_reg == S_DONE && (!out_valid_reg || out_ch.ready))
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
        end
        // Link the new block in after the current one
        if (ring_open)
        begin
            if (nb == '0)
            begin
                ring_reg[nb] <= nb;
            end
            else
            begin
                ring_reg[nb]          <= ring_reg[blk_reg];
                ring_reg[current_reg] <= nb;
            end
        end
    end

    // Map memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_q <= map_mem[{blk_next, byte_next}];
    end

    // Summary memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_q <= sum_mem[blk_next];
    end

    `BSSA_ASSERT_NOW(a_opened_bound, 1'b1,
        opened_reg <= bssa_pkg::OPEN_W'(bssa_pkg::NUM_BLOCKS))
    `BSSA_ASSERT_NOW(a_walk_needs_block, state_reg == S_SUM, opened_reg != '0)
    `BSSA_ASSERT_NOW(a_current_opened, opened_reg != '0,
        {1'b0, current_reg} < opened_reg)
    `BSSA_ASSERT_NEXT(a_open_grows, ring_open, opened_reg == $past(opened_reg) + 5'd1)

endmodule

// ===== tb/sv/alloc_checker.sv =====
`timescale 1ns / 100ps

module alloc_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [bssa_pkg::REQ_W-1:0] cfg_wr_data,
    bssa_in_if                         in_ch,
    bssa_out_if                        out_ch,
    output int                         mismatches,
    output int                         pending
);
    import bssa_pkg::*;

    typedef struct packed {
        status_t               status;
        logic [HANDLE_W-1:0]   handle;
    } outcome_t;

    // Shadow copy of the allocator state
    logic [7:0]          slot_map [NUM_BLOCKS*MAP_BYTES];
    logic                buf_taken [BUF_COUNT];
    logic [BLK_W-1:0]    ring_link [NUM_BLOCKS];
    logic [BLK_W-1:0]    cur_blk;
    int                  open_cnt;
    logic [REQ_W-1:0]    buf_size;
    outcome_t            outcomes_due [$];

    // Take the lowest free bit of the highest non-empty map byte of a block
    function automatic bit grab_slot(input int blk, output int slot);
        int b;
        int k;
        for (b = MAP_BYTES - 1; b >= 0; b--)
        begin
            if (slot_map[blk*MAP_BYTES + b] != 8'h00)
            begin
                for (k = 0; k < 8; k++)
                begin
                    if (slot_map[blk*MAP_BYTES + b][k])
                    begin
                        slot_map[blk*MAP_BYTES + b][k] = 1'b0;
                        slot = b*8 + k;
                        return 1'b1;
                    end
                end
            end
        end
        slot = 0;
        return 1'b0;
    endfunction

    function automatic outcome_t slab_take();
        outcome_t r;
        int blk;
        int n;
        int slot;
        int nb;
        blk = cur_blk;
        for (n = 0; n < open_cnt; n++)
        begin
            if (grab_slot(blk, slot))
            begin
                cur_blk = BLK_W'(blk);
                r.status = ST_SLAB;
                r.handle = HANDLE_W'(blk*512 + slot);
                return r;
            end
            blk = ring_link[blk];
        end
        if (open_cnt >= NUM_BLOCKS)
        begin
            r.status = ST_EXHAUSTED;
            r.handle = '0;
            return r;
        end
        // Open a new block and link it in after the current one
        nb = open_cnt;
        for (n = 0; n < MAP_BYTES; n++)
        begin
            slot_map[nb*MAP_BYTES + n] = 8'hFF;
        end
        if (nb == 0)
        begin
            ring_link[0] = '0;
        end
        else
        begin
            ring_link[nb] = ring_link[cur_blk];
            ring_link[cur_blk] = BLK_W'(nb);
        end
        open_cnt = nb + 1;
        cur_blk = BLK_W'(nb);
        void'(grab_slot(nb, slot));
        r.status = ST_SLAB;
        r.handle = HANDLE_W'(nb*512 + slot);
        return r;
    endfunction

    function automatic outcome_t predict_outcome(input logic act, input logic [REQ_W-1:0] req,
                                                 input logic pool, input logic [HANDLE_W-1:0] fh);
        outcome_t r;
        int i;
        int blk;
        int slot;
        if (act == ACT_ALLOC)
        begin
            if (buf_size != 0 && req == buf_size)
            begin
                for (i = 0; i < BUF_COUNT; i++)
                begin
                    if (!buf_taken[i])
                    begin
                        buf_taken[i] = 1'b1;
                        r.status = ST_BUFFER;
                        r.handle = HANDLE_W'(i);
                        return r;
                    end
                end
            end
            if (req > SLOT_BYTES)
            begin
                r.status = ST_TOO_LARGE;
                r.handle = '0;
                return r;
            end
            return slab_take();
        end
        r.handle = fh;
        r.status = ST_BAD_FREE;
        if (pool == POOL_BUFFER)
        begin
            if (fh < BUF_COUNT && buf_taken[fh])
            begin
                buf_taken[fh] = 1'b0;
                r.status = ST_FREED;
            end
        end
        else
        begin
            blk = fh / 512;
            slot = fh % 512;
            if (blk < open_cnt && !slot_map[blk*MAP_BYTES + slot/8][slot%8])
            begin
                slot_map[blk*MAP_BYTES + slot/8][slot%8] = 1'b1;
                r.status = ST_FREED;
            end
        end
        return r;
    endfunction

    assign pending = outcomes_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t e;
        outcome_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BLOCKS*MAP_BYTES; i++)
            begin
                slot_map[i] = 8'hFF;
            end
            for (int i = 0; i < BUF_COUNT; i++)
            begin
                buf_taken[i] = 1'b0;
            end
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                ring_link[i] = '0;
            end
            cur_blk = '0;
            open_cnt = 0;
            buf_size = '0;
            mismatches = 0;
            outcomes_due.delete();
        end
        else
        begin
            // Compare the result transfer against the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                got.status = status_t'(out_ch.status);
                got.handle = out_ch.handle;
                if (outcomes_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result: status %0d handle %0d",
                                 got.status, got.handle);
                    end
                end
                else
                begin
                    e = outcomes_due.pop_front();
                    if (got.status !== e.status || got.handle !== e.handle)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: expected status %0d handle %0d, got %0d %0d",
                                     e.status, e.handle, got.status, got.handle);
                        end
                    end
                end
            end
            // Predict the request transfer
            if (in_ch.valid && in_ch.ready)
            begin
                outcomes_due.push_back(predict_outcome(in_ch.action, in_ch.request_bytes,
                                                       in_ch.free_pool, in_ch.free_handle));
            end
            if (cfg_wr_en)
            begin
                buf_size = cfg_wr_data;
            end
        end
    end
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import bssa_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [REQ_W-1:0]   cfg_wr_data;
    int                 mismatches;
    int                 pending;
    bit                 idling_on;
    bit                 hold_request;
    logic [REQ_W-1:0]   buf_size;
    int                 slab_live [$];
    int                 buf_live [$];
    int                 last_pool;
    int                 last_handle;

    bssa_in_if  in_ch ();
    bssa_out_if out_ch ();

    bitmap_slab_slot_allocator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    alloc_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // Track granted handles so that frees can target live ones
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (out_ch.status == ST_SLAB)
            begin
                slab_live.push_back(out_ch.handle);
            end
            else if (out_ch.status == ST_BUFFER)
            begin
                buf_live.push_back(out_ch.handle);
            end
        end
    end

    // Result side: random stalls, plus one long hold when requested
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            if (hold_request)
            begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                out_ch.ready <= !(idling_on && $urandom_range(99) < 35);
                @(posedge clk);
            end
        end
    end

    task automatic send(input logic act, input logic [REQ_W-1:0] req,
                        input logic pool, input logic [HANDLE_W-1:0] fh);
        if (idling_on && $urandom_range(99) < 35)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= act;
        in_ch.request_bytes <= req;
        in_ch.free_pool     <= pool;
        in_ch.free_handle   <= fh;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Write the buffer size once the allocator has drained
    task automatic set_buffer_size(input logic [REQ_W-1:0] v);
        in_ch.valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        buf_size = v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic free_handle_of(input int pool, input int h);
        last_pool = pool;
        last_handle = h;
        send(ACT_FREE, REQ_W'($urandom), pool[0], HANDLE_W'(h));
    endtask

    task automatic random_request();
        int pick;
        int idx;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                send(ACT_ALLOC, buf_size, 1'($urandom), HANDLE_W'($urandom));
            else if (pick < 75)
                send(ACT_ALLOC, REQ_W'($urandom_range(0, SLOT_BYTES)), 1'($urandom),
                     HANDLE_W'($urandom));
            else if (pick < 83)
                send(ACT_ALLOC, REQ_W'(SLOT_BYTES + 1), 1'($urandom), HANDLE_W'($urandom));
            else
                send(ACT_ALLOC, REQ_W'($urandom), 1'($urandom), HANDLE_W'($urandom));
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 40 && slab_live.size() > 0)
            begin
                idx = $urandom_range(slab_live.size() - 1);
                free_handle_of(POOL_SLAB, slab_live[idx]);
                slab_live.delete(idx);
            end
            else if (pick < 70 && buf_live.size() > 0)
            begin
                idx = $urandom_range(buf_live.size() - 1);
                free_handle_of(POOL_BUFFER, buf_live[idx]);
                buf_live.delete(idx);
            end
            else if (pick < 82)
                free_handle_of(last_pool, last_handle);
            else
                free_handle_of($urandom_range(1), $urandom_range(8191));
        end
    endtask

    initial
    begin
        logic [REQ_W-1:0] sizes [5];
        sizes = '{16'd64, 16'hFFFF, 16'd1, 16'd40, 16'd200};
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        idling_on     = 1'b0;
        hold_request  = 1'b0;
        buf_size      = '0;
        last_pool     = 0;
        last_handle   = 0;
        in_ch.valid         = 1'b0;
        in_ch.action        = ACT_ALLOC;
        in_ch.request_bytes = '0;
        in_ch.free_pool     = POOL_SLAB;
        in_ch.free_handle   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: slab path, size extremes, bad frees of every kind
        set_buffer_size(16'd0);
        send(ACT_ALLOC, 16'd0, POOL_SLAB, '0);
        send(ACT_ALLOC, 16'd64, POOL_SLAB, '0);
        send(ACT_ALLOC, 16'd65, POOL_SLAB, '0);
        send(ACT_ALLOC, 16'hFFFF, POOL_BUFFER, 13'h1FFF);
        send(ACT_FREE, 16'hFFFF, POOL_SLAB, 13'd511);
        send(ACT_FREE, 16'hFFFF, POOL_SLAB, 13'd511);
        send(ACT_FREE, 16'd0, POOL_SLAB, 13'd510);
        send(ACT_FREE, 16'd0, POOL_SLAB, 13'h1FFF);
        send(ACT_FREE, 16'd0, POOL_BUFFER, 13'd63);
        send(ACT_FREE, 16'd0, POOL_BUFFER, 13'd64);
        send(ACT_FREE, 16'd0, POOL_BUFFER, 13'h1FFF);

        // Directed: buffer pool grants and frees
        set_buffer_size(16'd64);
        send(ACT_ALLOC, 16'd64, POOL_SLAB, '0);
        send(ACT_ALLOC, 16'd64, POOL_SLAB, '0);
        send(ACT_FREE, 16'd0, POOL_BUFFER, 13'd0);
        send(ACT_FREE, 16'd0, POOL_BUFFER, 13'd0);
        send(ACT_ALLOC, 16'd64, POOL_SLAB, '0);
        send(ACT_ALLOC, 16'd63, POOL_SLAB, '0);
        slab_live.delete();
        buf_live.delete();

        // Random phases across several buffer sizes
        for (int p = 0; p < 5; p++)
        begin
            set_buffer_size(sizes[p]);
            for (int n = 0; n < 200; n++)
            begin
                idling_on = !(p == 2 && n < 120);
                if (p == 1 && n == 100)
                    hold_request = 1'b1;
                random_request();
            end
        end

        // Load the slab with back-to-back grants so that further blocks open
        set_buffer_size(16'd8);
        idling_on = 1'b0;
        for (int n = 0; n < 400; n++)
        begin
            send(ACT_ALLOC, REQ_W'($urandom_range(0, SLOT_BYTES)), 1'($urandom),
                 HANDLE_W'($urandom));
        end
        idling_on = 1'b1;
        for (int n = 0; n < 30; n++)
        begin
            random_request();
        end
        in_ch.valid <= 1'b0;

        // Drain and settle
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bssa_pkg.sv
rtl/bssa_if.sv
rtl/bitmap_slab_slot_allocator.sv
tb/sv/alloc_checker.sv
tb/sv/tb.sv
